>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the lane and top-level RTL modules of the masked smoother.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MGS_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MGS_ASSERT(lbl, ante, cons, msg)
`define MGS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/mgs_pkg.sv
// Types, constants and helper functions of the masked Gaussian smoother.
`default_nettype none
package mgs_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int CHANNEL_BITS = 8;

    localparam int NUM_CH   = 3;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WREG_W = 11;
    localparam int HREG_W = 13;
    localparam int ROW_W  = 13;
    localparam int UW_W   = (COL_W + 1 > WREG_W) ? COL_W + 1 : WREG_W;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
    localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd64;
    localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd64;

    localparam int TAPS     = 9;
    localparam int WEIGHT_W = 3;
    localparam int NORM_W   = 5;
    localparam int SUM_W    = CHANNEL_BITS + 4;
    localparam int NUM_W    = SUM_W + 1;
    localparam int DIV_W    = NORM_W + CHANNEL_BITS;
    localparam int CMP_W    = ((NUM_W > DIV_W) ? NUM_W : DIV_W) + 1;
    localparam int STEP_W   = $clog2(CHANNEL_BITS);

    localparam logic [WEIGHT_W-1:0] KERNEL_WEIGHT [TAPS] = '{
        3'd1, 3'd2, 3'd1,
        3'd2, 3'd4, 3'd2,
        3'd1, 3'd2, 3'd1
    };

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] blue;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] red;
        logic                    covered;
    } pixel_t;

    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_pair_t;

    typedef struct packed {
        logic                    pad;
        logic                    covered;
        logic [CHANNEL_BITS-1:0] red_in;
        logic [CHANNEL_BITS-1:0] green_in;
        logic [CHANNEL_BITS-1:0] blue_in;
    } in_word_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red_out;
        logic [CHANNEL_BITS-1:0] green_out;
        logic [CHANNEL_BITS-1:0] blue_out;
        logic                    covered_out;
        logic                    frame_end;
    } out_word_t;

    typedef struct packed {
        logic              start;
        logic [TAPS-1:0]   taps;
        logic [NORM_W-1:0] norm;
    } lane_req_t;

    typedef struct packed {
        logic                    done;
        logic [CHANNEL_BITS-1:0] quotient;
    } lane_sts_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_TAPS,
        S_DIV,
        S_DONE
    } state_t;

    function automatic logic [CHANNEL_BITS-1:0] pixel_chan(pixel_t p, int c);
        logic [CHANNEL_BITS-1:0] v;
        case (c)
            CH_RED:   v = p.red;
            CH_GREEN: v = p.green;
            default:  v = p.blue;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/mgs_line_ram.sv
// Line store memory holding the upper and middle rows for each column.
`default_nettype none
module mgs_line_ram (
    input  logic                            clk,
    input  logic                            we,
    input  logic [mgs_pkg::COL_W-1:0]       waddr,
    input  mgs_pkg::line_pair_t             wdata,
    input  logic [mgs_pkg::COL_W-1:0]       raddr,
    output mgs_pkg::line_pair_t             rdata
);
    import mgs_pkg::*;

    line_pair_t mem [MAX_WIDTH];
    line_pair_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> hw/rtl/mgs_lane.sv
// One channel lane: weighted neighbour sum and bit-serial rounding divider.
`default_nettype none
`include "assert_macros.svh"
module mgs_lane (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  mgs_pkg::lane_req_t                                     req,
    input  logic [mgs_pkg::TAPS-1:0][mgs_pkg::CHANNEL_BITS-1:0]    chan,
    output mgs_pkg::lane_sts_t                                     sts
);
    import mgs_pkg::*;

    logic [SUM_W-1:0]        sum;
    logic [NUM_W-1:0]        num;
    logic [DIV_W-1:0]        den_top;
    logic                    fits;
    logic [NUM_W-1:0]        rem_next;

    logic [NUM_W-1:0]        rem_reg;
    logic [DIV_W-1:0]        d_reg;
    logic [CHANNEL_BITS-1:0] quo_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    busy_reg;
    logic                    done_reg;

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < TAPS; k++)
        begin
            if (req.taps[k])
            begin
                sum = sum + SUM_W'(chan[k]) * SUM_W'(KERNEL_WEIGHT[k]);
            end
        end
        num     = {sum, 1'b0} + NUM_W'(req.norm);
        den_top = DIV_W'({req.norm, 1'b0}) << (CHANNEL_BITS - 1);
    end

    always_comb
    begin
        fits     = CMP_W'(rem_reg) >= CMP_W'(d_reg);
        rem_next = fits ? rem_reg - NUM_W'(d_reg) : rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(CHANNEL_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= num;
            d_reg   <= den_top;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            d_reg   <= d_reg >> 1;
            quo_reg <= {quo_reg[CHANNEL_BITS-2:0], fits};
        end
    end

    assign sts.done     = done_reg;
    assign sts.quotient = quo_reg;

    `MGS_ASSERT(a_start_when_free, req.start, !busy_reg, "lane started while busy")
    `MGS_ASSERT_NEXT(a_start_busy, req.start, busy_reg, "lane did not begin dividing")
    `MGS_ASSERT(a_divisor_nonzero, busy_reg, d_reg != '0, "lane divides by zero")

endmodule
`default_nettype wire

>>> hw/rtl/masked_gaussian_smoother_core.sv
// Top level of the masked, normalized 3x3 Gaussian smoother.
//
// Pixels enter in raster order on the src channel (valid/stall); a word is
// taken when src_valid is high and src_stall is low. Results leave on the
// dst channel, which holds each word until dst_valid is high and dst_stall
// is low. Each result belongs to the pixel one row plus one pixel behind
// the input, so frame_width + 1 pad words flush the last row.
// The block works on one word at a time. A word whose centre is covered
// goes through the line store read, a window update and a bit-serial
// division run in three channel lanes side by side before the next word
// is taken. An uncovered centre skips the division; a word with no result
// ends after the window update. The result enters the output register
// as the block leaves its done state; a new word may enter while it waits.
// If the output register is still full when the next result is finished,
// the block holds and keeps src_stall high until dst_stall drops.
// Reset sets the frame to 64 by 64 and the position to the first pixel;
// the line stores need no clearing. A configuration write also restarts
// the frame position.
`default_nettype none
`include "assert_macros.svh"
module masked_gaussian_smoother_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 src_valid,
    output logic                                 src_stall,
    input  mgs_pkg::in_word_t                    src_word,
    output logic                                 dst_valid,
    input  logic                                 dst_stall,
    output mgs_pkg::out_word_t                   dst_word,
    input  logic                                 cfg_we,
    input  logic [mgs_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mgs_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import mgs_pkg::*;

    state_t             state_reg;
    state_t             state_next;

    logic [WREG_W-1:0]  width_reg;
    logic [HREG_W-1:0]  height_reg;
    logic [UW_W-1:0]    used_w;
    logic [HREG_W-1:0]  used_h;

    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [ROW_W-1:0]   cr_reg;
    logic [ROW_W-1:0]   cr_next;
    logic [COL_W-1:0]   cc_reg;
    logic [COL_W-1:0]   cc_next;
    logic               last_reg;
    logic               last_next;
    logic               emit;

    logic [UW_W-1:0]    col_inc;
    logic               wrap;
    logic [ROW_W:0]     row_adv;

    pixel_t             px_reg;
    pixel_t             px_next;
    pixel_t             win_reg [3][3];
    pixel_t             centre;
    line_pair_t         rd_pair;
    line_pair_t         wr_pair;

    logic               accept;
    logic               ram_we;
    logic               load_out;
    logic               lane_start;
    logic [2:0]         row_ok;
    logic [2:0]         col_ok;
    logic [TAPS-1:0]    taps;
    logic [NORM_W-1:0]  norm;
    lane_req_t          lane_req;
    lane_sts_t          lane_sts [NUM_CH];
    logic [TAPS-1:0][CHANNEL_BITS-1:0] lane_chan [NUM_CH];

    logic               dst_valid_reg;
    out_word_t          dst_word_reg;

    // Registers out of range are clamped to the supported frame size.
    always_comb
    begin
        if (width_reg == '0)
        begin
            used_w = UW_W'(1);
        end
        else if (UW_W'(width_reg) > UW_W'(MAX_WIDTH))
        begin
            used_w = UW_W'(MAX_WIDTH);
        end
        else
        begin
            used_w = UW_W'(width_reg);
        end

        if (height_reg == '0)
        begin
            used_h = HREG_W'(1);
        end
        else if (height_reg > HREG_W'(MAX_HEIGHT))
        begin
            used_h = HREG_W'(MAX_HEIGHT);
        end
        else
        begin
            used_h = height_reg;
        end
    end

    always_comb
    begin
        px_next = '0;
        if (!src_word.pad && (row_reg < used_h))
        begin
            px_next.covered = src_word.covered;
            px_next.red     = src_word.red_in;
            px_next.green   = src_word.green_in;
            px_next.blue    = src_word.blue_in;
        end
    end

    // Position of the centre that the current word completes, and the
    // position of the next word.
    always_comb
    begin
        if (col_reg != '0)
        begin
            emit    = row_reg >= ROW_W'(1);
            cr_next = row_reg - ROW_W'(1);
            cc_next = col_reg - COL_W'(1);
        end
        else
        begin
            emit    = row_reg >= ROW_W'(2);
            cr_next = row_reg - ROW_W'(2);
            cc_next = COL_W'(used_w - UW_W'(1));
        end
        last_next = emit && (cr_next == used_h - HREG_W'(1))
                         && (UW_W'(cc_next) == used_w - UW_W'(1));

        col_inc = UW_W'(col_reg) + UW_W'(1);
        wrap    = col_inc >= used_w;
        col_next = wrap ? '0 : COL_W'(col_inc);
        row_adv  = wrap ? {1'b0, row_reg} + (ROW_W + 1)'(1) : {1'b0, row_reg};

        if (emit && (last_next || (row_adv > (ROW_W + 1)'(used_h) + (ROW_W + 1)'(1))))
        begin
            col_next = '0;
            row_next = '0;
        end
        else
        begin
            row_next = ROW_W'(row_adv);
        end
    end

    assign centre = win_reg[1][1];

    // Neighbours that lie inside the frame and are covered.
    always_comb
    begin
        row_ok[0] = cr_reg != '0;
        row_ok[1] = cr_reg < used_h;
        row_ok[2] = ({1'b0, cr_reg} + (ROW_W + 1)'(1)) < (ROW_W + 1)'(used_h);
        col_ok[0] = cc_reg != '0;
        col_ok[1] = UW_W'(cc_reg) < used_w;
        col_ok[2] = (UW_W'(cc_reg) + UW_W'(1)) < used_w;
        norm = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                taps[i * 3 + j] = row_ok[i] && col_ok[j] && win_reg[i][j].covered;
                if (taps[i * 3 + j])
                begin
                    norm = norm + NORM_W'(KERNEL_WEIGHT[i * 3 + j]);
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    lane_chan[c][i * 3 + j] = pixel_chan(win_reg[i][j], c);
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (src_valid)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = emit ? S_TAPS : S_IDLE;
            end
            S_TAPS:
            begin
                state_next = centre.covered ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (lane_sts[CH_RED].done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!dst_valid_reg || !dst_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        src_stall  = 1'b1;
        accept     = 1'b0;
        ram_we     = 1'b0;
        lane_start = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                src_stall = 1'b0;
                accept    = src_valid;
            end
            S_LOAD:
            begin
                ram_we = 1'b1;
            end
            S_TAPS:
            begin
                lane_start = centre.covered;
            end
            S_DONE:
            begin
                load_out = !dst_valid_reg || !dst_stall;
            end
            default:
            begin
                src_stall = 1'b1;
            end
        endcase
    end

    assign lane_req.start = lane_start;
    assign lane_req.taps  = taps;
    assign lane_req.norm  = norm;

    assign wr_pair.upper  = rd_pair.middle;
    assign wr_pair.middle = px_reg;

    mgs_line_ram u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (wr_pair),
        .raddr (col_reg),
        .rdata (rd_pair)
    );

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        mgs_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .req   (lane_req),
            .chan  (lane_chan[c]),
            .sts   (lane_sts[c])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            dst_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= WREG_W'(cfg_data);
                    REG_FRAME_HEIGHT: height_reg <= HREG_W'(cfg_data);
                    default:          width_reg  <= width_reg;
                endcase
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (ram_we)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end

            if (ram_we)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= rd_pair.upper;
                win_reg[1][2] <= rd_pair.middle;
                win_reg[2][2] <= px_reg;
            end

            if (load_out)
            begin
                dst_valid_reg <= 1'b1;
            end
            else if (!dst_stall)
            begin
                dst_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= px_next;
        end
        if (ram_we)
        begin
            cr_reg   <= cr_next;
            cc_reg   <= cc_next;
            last_reg <= last_next;
        end
        if (load_out)
        begin
            dst_word_reg.red_out     <= centre.covered ? lane_sts[CH_RED].quotient
                                                       : centre.red;
            dst_word_reg.green_out   <= centre.covered ? lane_sts[CH_GREEN].quotient
                                                       : centre.green;
            dst_word_reg.blue_out    <= centre.covered ? lane_sts[CH_BLUE].quotient
                                                       : centre.blue;
            dst_word_reg.covered_out <= centre.covered;
            dst_word_reg.frame_end   <= last_reg;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_word  = dst_word_reg;

    `MGS_ASSERT(a_col_in_frame, state_reg == S_IDLE, UW_W'(col_reg) < used_w, "column outside frame")
    `MGS_ASSERT(a_lanes_lockstep, lane_sts[CH_RED].done, lane_sts[CH_GREEN].done && lane_sts[CH_BLUE].done, "lanes out of step")
    `MGS_ASSERT(a_result_from_done, $rose(dst_valid_reg), $past(state_reg) == S_DONE, "result loaded outside done state")

endmodule
`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the masked Gaussian smoother core.
module tb;
    import mgs_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_LIMIT  = 500_000;
    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_WORDS  = 600;
    localparam int LONG_HOLD     = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic src_valid = 1'b0;
    logic src_stall;
    in_word_t src_word = '0;
    logic dst_valid;
    logic dst_stall = 1'b0;
    out_word_t dst_word;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    in_word_t pixel_queue [$];
    out_word_t smoothed_q [$];
    logic src_taken = 1'b0;
    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    logic hold_armed = 1'b0;
    int hold_left = LONG_HOLD;
    int cycle_count = 0;

    pixel_t upper_store [MAX_WIDTH];
    pixel_t middle_store [MAX_WIDTH];
    pixel_t win [3][3];
    int col_pos = 0;
    int row_pos = 0;
    int width_used = 64;
    int height_used = 64;

    int words_sent = 0;
    int results_checked = 0;
    int frame_ends = 0;
    int reg_writes = 0;
    int mismatch_count = 0;

    masked_gaussian_smoother_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .src_valid(src_valid),
        .src_stall(src_stall),
        .src_word(src_word),
        .dst_valid(dst_valid),
        .dst_stall(dst_stall),
        .dst_word(dst_word),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    task automatic smooth_word(input in_word_t w);
        pixel_t px;
        pixel_t ctr;
        pixel_t nb;
        out_word_t res;
        int i, j, li, cr, cc, nr, nc, wt, norm, sum_r, sum_g, sum_b;
        logic last;
        px = '0;
        if (!w.pad && row_pos < height_used)
        begin
            px.covered = w.covered;
            px.red = w.red_in;
            px.green = w.green_in;
            px.blue = w.blue_in;
        end
        li = col_pos % MAX_WIDTH;
        for (i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = upper_store[li];
        win[1][2] = middle_store[li];
        win[2][2] = px;
        upper_store[li] = middle_store[li];
        middle_store[li] = px;
        if (col_pos >= 1)
        begin
            cr = row_pos - 1;
            cc = col_pos - 1;
        end
        else
        begin
            cr = row_pos - 2;
            cc = width_used - 1;
        end
        col_pos++;
        if (col_pos >= width_used)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (cr >= 0)
        begin
            ctr = win[1][1];
            last = (cr == height_used - 1) && (cc == width_used - 1);
            res = '0;
            res.red_out = ctr.red;
            res.green_out = ctr.green;
            res.blue_out = ctr.blue;
            if (ctr.covered)
            begin
                norm = 0;
                sum_r = 0;
                sum_g = 0;
                sum_b = 0;
                for (i = 0; i < 3; i++)
                begin
                    for (j = 0; j < 3; j++)
                    begin
                        nr = cr + i - 1;
                        nc = cc + j - 1;
                        nb = win[i][j];
                        if (nr >= 0 && nr < height_used && nc >= 0 && nc < width_used
                            && nb.covered)
                        begin
                            wt = ((i == 1) ? 2 : 1) * ((j == 1) ? 2 : 1);
                            norm += wt;
                            sum_r += wt * int'(nb.red);
                            sum_g += wt * int'(nb.green);
                            sum_b += wt * int'(nb.blue);
                        end
                    end
                end
                res.red_out = 8'((2 * sum_r + norm) / (2 * norm));
                res.green_out = 8'((2 * sum_g + norm) / (2 * norm));
                res.blue_out = 8'((2 * sum_b + norm) / (2 * norm));
            end
            res.covered_out = ctr.covered;
            res.frame_end = last;
            smoothed_q.insert(smoothed_q.size(), res);
            if (last || row_pos > height_used + 1)
            begin
                col_pos = 0;
                row_pos = 0;
            end
        end
    endtask

    always @(posedge clk)
    begin : result_checker
        out_word_t want;
        src_taken <= rst_n && src_valid && !src_stall;
        if (rst_n)
        begin
            if (dst_valid && !dst_stall)
            begin
                if (smoothed_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: expected no word, got r=%0d g=%0d b=%0d cov=%0b end=%0b",
                             $time, dst_word.red_out, dst_word.green_out,
                             dst_word.blue_out, dst_word.covered_out, dst_word.frame_end);
                end
                else
                begin
                    want = smoothed_q.pop_front();
                    results_checked++;
                    if (want.frame_end)
                        frame_ends++;
                    if (dst_word.red_out !== want.red_out
                        || dst_word.green_out !== want.green_out
                        || dst_word.blue_out !== want.blue_out
                        || dst_word.covered_out !== want.covered_out
                        || dst_word.frame_end !== want.frame_end)
                    begin
                        mismatch_count++;
                        $display({"%0t: expected r=%0d g=%0d b=%0d cov=%0b end=%0b,",
                                  " got r=%0d g=%0d b=%0d cov=%0b end=%0b"},
                                 $time, want.red_out, want.green_out, want.blue_out,
                                 want.covered_out, want.frame_end,
                                 dst_word.red_out, dst_word.green_out, dst_word.blue_out,
                                 dst_word.covered_out, dst_word.frame_end);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:
                    begin
                        width_used = int'(cfg_data[WREG_W-1:0]);
                        if (width_used == 0)
                            width_used = 1;
                        else if (width_used > MAX_WIDTH)
                            width_used = MAX_WIDTH;
                    end
                    REG_FRAME_HEIGHT:
                    begin
                        height_used = int'(cfg_data[HREG_W-1:0]);
                        if (height_used == 0)
                            height_used = 1;
                        else if (height_used > MAX_HEIGHT)
                            height_used = MAX_HEIGHT;
                    end
                    default:
                    begin
                    end
                endcase
                col_pos = 0;
                row_pos = 0;
            end
            if (src_valid && !src_stall)
                smooth_word(src_word);
        end
    end

    always @(negedge clk)
    begin : src_driver
        if (!src_valid || src_taken)
        begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                src_word <= pixel_queue.pop_front();
                src_valid <= 1'b1;
            end
            else
            begin
                src_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : dst_driver
        if (hold_armed && hold_left > 0)
        begin
            dst_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            dst_stall <= ($urandom_range(99) < dst_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_word(input logic pad, input logic covered,
                             input logic [CHANNEL_BITS-1:0] r,
                             input logic [CHANNEL_BITS-1:0] g,
                             input logic [CHANNEL_BITS-1:0] b);
        in_word_t word;
        word.pad = pad;
        word.covered = covered;
        word.red_in = r;
        word.green_in = g;
        word.blue_in = b;
        pixel_queue.insert(pixel_queue.size(), word);
        words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        reg_writes++;
    endtask

    task automatic settle(input int extra);
        int waited;
        waited = 0;
        while ((pixel_queue.size() != 0 || src_valid || smoothed_q.size() != 0)
               && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (extra) @(posedge clk);
    endtask

    function automatic logic [CHANNEL_BITS-1:0] pick_level();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        return CHANNEL_BITS'($urandom_range(255));
    endfunction

    task automatic queue_frame(input int wd, input int ht, input bit allow_breaks);
        int cover_pct, pixels, flush, k, pause_at;
        pixels = wd * ht;
        flush = wd + 1;
        pause_at = allow_breaks ? -1 : pixels / 2 + 1;
        case ($urandom_range(3))
            0: cover_pct = 100;
            1: cover_pct = 0;
            2: cover_pct = 50;
            default: cover_pct = 90;
        endcase
        if (allow_breaks)
        begin
            if ($urandom_range(19) == 0)
                pixels = $urandom_range(pixels);
            if ($urandom_range(9) == 0)
                flush = $urandom_range(wd + 2);
            if ($urandom_range(19) == 0)
                pause_at = $urandom_range(pixels);
        end
        for (k = 0; k < pixels; k++)
        begin
            if (k == pause_at)
                settle(0);
            push_word($urandom_range(99) < 3, $urandom_range(99) < cover_pct,
                      pick_level(), pick_level(), pick_level());
        end
        for (k = 0; k < flush; k++)
            push_word($urandom_range(9) != 0, $urandom_range(1),
                      pick_level(), pick_level(), pick_level());
    endtask

    initial
    begin : stimulus
        int k, wd, ht;
        for (k = 0; k < MAX_WIDTH; k++)
        begin
            upper_store[k] = '0;
            middle_store[k] = '0;
        end
        for (k = 0; k < 9; k++)
            win[k / 3][k % 3] = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        src_idle_pct = 29;
        dst_idle_pct = 76;

        // Small frame with saturated, zero, uncovered and padded pixels, then a
        // pixel word standing in for a flush word.
        write_reg(REG_FRAME_WIDTH, 13'd3);
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        push_word(1'b0, 1'b1, 8'd255, 8'd255, 8'd255);
        push_word(1'b0, 1'b1, 8'd0, 8'd0, 8'd0);
        push_word(1'b0, 1'b0, 8'd17, 8'd200, 8'd3);
        push_word(1'b1, 1'b1, 8'd90, 8'd91, 8'd92);
        push_word(1'b0, 1'b1, 8'd1, 8'd2, 8'd3);
        push_word(1'b0, 1'b1, 8'd255, 8'd0, 8'd128);
        push_word(1'b0, 1'b1, 8'd9, 8'd9, 8'd9);
        for (k = 0; k < 3; k++)
            push_word(1'b1, 1'b0, 8'd0, 8'd0, 8'd0);
        settle(SETTLE_CYCLES);

        // A width of zero behaves as a single column.
        write_reg(REG_FRAME_WIDTH, 13'd0);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        push_word(1'b0, 1'b1, 8'd255, 8'd0, 8'd255);
        push_word(1'b0, 1'b1, 8'd0, 8'd255, 8'd0);
        push_word(1'b0, 1'b0, 8'd77, 8'd66, 8'd55);
        push_word(1'b1, 1'b0, 8'd0, 8'd0, 8'd0);
        push_word(1'b1, 1'b0, 8'd0, 8'd0, 8'd0);
        settle(SETTLE_CYCLES);

        // One row whose middle sum lands exactly halfway between two levels.
        write_reg(REG_FRAME_WIDTH, 13'd3);
        write_reg(REG_FRAME_HEIGHT, 13'd1);
        push_word(1'b0, 1'b1, 8'd2, 8'd255, 8'd1);
        push_word(1'b0, 1'b1, 8'd0, 8'd254, 8'd0);
        push_word(1'b0, 1'b1, 8'd0, 8'd255, 8'd1);
        for (k = 0; k < 4; k++)
            push_word(1'b1, 1'b1, 8'd255, 8'd255, 8'd255);

        while (words_sent < RANDOM_WORDS)
        begin
            settle(SETTLE_CYCLES);
            if (words_sent < RANDOM_WORDS / 3)
            begin
                src_idle_pct = 29;
                dst_idle_pct = 76;
            end
            else if (words_sent < 2 * RANDOM_WORDS / 3)
            begin
                src_idle_pct = 76;
                dst_idle_pct = 29;
            end
            else
            begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
                hold_armed = 1'b1;
            end
            k = $urandom_range(99);
            wd = (k < 5) ? 0 : (k < 15) ? 1 : (k < 25) ? 2 :
                 (k < 85) ? $urandom_range(3, 8) : $urandom_range(9, 24);
            if ($urandom_range(4) == 0)
                write_reg(REG_FRAME_WIDTH, {2'($urandom_range(3)), 11'(wd)});
            else
                write_reg(REG_FRAME_WIDTH, 13'(wd));
            k = $urandom_range(99);
            ht = (k < 5) ? 0 : (k < 20) ? 1 : $urandom_range(2, 5);
            if ($urandom_range(5) != 0)
                write_reg(REG_FRAME_HEIGHT, 13'(ht));
            for (k = $urandom_range(1, 3); k > 0; k--)
                queue_frame(width_used, height_used, 1'b1);
        end

        // Register extremes: full height, full width, and values beyond both.
        settle(SETTLE_CYCLES);
        write_reg(REG_FRAME_WIDTH, 13'd2);
        write_reg(REG_FRAME_HEIGHT, 13'd4096);
        for (k = 0; k < 6; k++)
            push_word(1'b0, 1'b1, pick_level(), pick_level(), pick_level());
        settle(SETTLE_CYCLES);
        write_reg(REG_FRAME_WIDTH, 13'd2047);
        write_reg(REG_FRAME_HEIGHT, 13'd0);
        for (k = 0; k < MAX_WIDTH + 40; k++)
            push_word(1'b0, $urandom_range(99) < 90,
                      pick_level(), pick_level(), pick_level());
        settle(SETTLE_CYCLES);
        write_reg(REG_FRAME_WIDTH, 13'd0);
        write_reg(REG_FRAME_HEIGHT, 13'd8191);
        for (k = 0; k < 8; k++)
            push_word(1'b0, 1'b1, pick_level(), pick_level(), pick_level());
        settle(SETTLE_CYCLES);

        if (smoothed_q.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d expected words never arrived", $time, smoothed_q.size());
        end
        $display("Sent %0d pixel words and checked %0d results over %0d register writes,",
                 words_sent, results_checked, reg_writes);
        $display("with %0d frame ends, rows up to the full 1024-pixel line store.",
                 frame_ends);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
